// ----- hdl/udf_pkg.sv -----
// Package for the USB endpoint descriptor finder.
// Holds the configuration register indexes, descriptor type codes and the
// shared configuration and result structs. No dependencies.
package udf_pkg;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 8;

  // Descriptor type codes that the walk reacts to.
  localparam logic [7:0] DescKindInterface = 8'd4;
  localparam logic [7:0] DescKindEndpoint  = 8'd5;

  typedef enum logic [CfgAddrWidth-1:0] {
    CfgNumConfigs     = 3'd0,
    CfgWantedConfig   = 3'd1,
    CfgWantedIntf     = 3'd2,
    CfgWantedAlt      = 3'd3,
    CfgAddrMatchValue = 3'd4,
    CfgAddrMatchMask  = 3'd5,
    CfgWantedXferType = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] num_configs;
    logic [7:0] wanted_config_value;
    logic [7:0] wanted_interface;
    logic [7:0] wanted_alternate;
    logic [7:0] addr_match_value;
    logic [7:0] addr_match_mask;
    logic [1:0] wanted_xfer_type;
  } cfg_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  endpoint_number;
    logic [15:0] max_packet_size;
  } result_t;

endpackage

// ----- hdl/usb_endpoint_descriptor_finder.sv -----
// A result is registered into the output entry, or into the skid entry while the
// output entry is held. One descriptor byte is taken per cycle while the skid
// entry is free; the per-byte walk is a single pass of compares and counters,
// and a two-entry output buffer keeps the input side open while one result
// waits. Reset: asynchronous, active low; configuration registers return to
// their defaults and the stream state to empty. Depends on udf_pkg and udf_walker.
module usb_endpoint_descriptor_finder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [udf_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [udf_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  // Descriptor byte stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] desc_byte
  input  logic                              s_axis_tlast,  // last_byte
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // [3:0] endpoint_number,
                                                           // [19:4] max_packet_size
  output logic                              m_axis_tuser   // found
);

  udf_pkg::cfg_t    cfg_q;
  udf_pkg::result_t res;
  udf_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic             res_valid;
  logic             in_xfer;
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_configs         <= 8'd1;
      cfg_q.wanted_config_value <= 8'd1;
      cfg_q.wanted_interface    <= 8'd0;
      cfg_q.wanted_alternate    <= 8'd0;
      cfg_q.addr_match_value    <= 8'd0;
      cfg_q.addr_match_mask     <= 8'd128;
      cfg_q.wanted_xfer_type    <= 2'd2;
    end else if (cfg_we_i) begin
      case (udf_pkg::cfg_idx_e'(cfg_addr_i))
        udf_pkg::CfgNumConfigs:     cfg_q.num_configs         <= cfg_wdata_i;
        udf_pkg::CfgWantedConfig:   cfg_q.wanted_config_value <= cfg_wdata_i;
        udf_pkg::CfgWantedIntf:     cfg_q.wanted_interface    <= cfg_wdata_i;
        udf_pkg::CfgWantedAlt:      cfg_q.wanted_alternate    <= cfg_wdata_i;
        udf_pkg::CfgAddrMatchValue: cfg_q.addr_match_value    <= cfg_wdata_i;
        udf_pkg::CfgAddrMatchMask:  cfg_q.addr_match_mask     <= cfg_wdata_i;
        udf_pkg::CfgWantedXferType: cfg_q.wanted_xfer_type    <= cfg_wdata_i[1:0];
        default:                    cfg_q                     <= cfg_q;
      endcase
    end
  end

  // Bytes are taken as long as the skid entry is free.
  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  udf_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (in_xfer),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_valid_q && m_axis_tready) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_d) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = {4'd0, out_q.max_packet_size, out_q.endpoint_number};

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output entry is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && res_valid) |=> skid_valid_q)
    else $error("result lost while the output entry was stalled");

  a_result_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result produced without a last byte transaction");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 24'd0))
    else $error("nonzero fields on a result with no match");

endmodule

// ----- hdl/udf_walker.sv -----
// Descriptor stream walker: tracks configuration blocks and descriptors byte by
// byte and captures the first matching endpoint descriptor.
// Depends on udf_pkg.
module udf_walker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  udf_pkg::cfg_t    cfg_i,
  input  logic             byte_valid_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output logic             res_valid_o,
  output udf_pkg::result_t res_o
);

  typedef struct packed {
    logic [15:0] cfg_offset;
    logic [15:0] cfg_total_len;
    logic [7:0]  cfg_count;
    logic        in_wanted_cfg;
    logic [7:0]  desc_offset;
    logic [7:0]  desc_length;
    logic [7:0]  desc_kind;
    logic [7:0]  cur_interface;
    logic [7:0]  cur_alternate;
    logic [7:0]  ep_addr_hold;
    logic [7:0]  ep_attr_hold;
    logic [7:0]  size_low_hold;
    logic        match_done;
    logic [3:0]  found_endpoint;
    logic [15:0] found_size;
    logic        walk_over;
    logic        desc_stall;
  } walk_state_t;

  walk_state_t st_q, st_d, upd;
  logic [7:0]  cnt_inc;
  logic        block_end;
  logic        ep_match;

  always_comb begin
    upd       = st_q;
    cnt_inc   = st_q.cfg_count + 8'd1;
    block_end = 1'b0;
    ep_match  = 1'b0;

    if (!st_q.walk_over) begin
      if (st_q.cfg_count >= cfg_i.num_configs) begin
        upd.walk_over = 1'b1;
      end else begin
        // Header fields of the configuration descriptor at the block start.
        case (st_q.cfg_offset)
          16'd2:   upd.cfg_total_len = {st_q.cfg_total_len[15:8], byte_i};
          16'd3:   upd.cfg_total_len = {byte_i, st_q.cfg_total_len[7:0]};
          16'd5:   upd.in_wanted_cfg = (byte_i == cfg_i.wanted_config_value);
          default: upd.cfg_total_len = st_q.cfg_total_len;
        endcase

        if (!st_q.desc_stall) begin
          if (st_q.desc_offset == 8'd0) begin
            upd.desc_length = byte_i;
            if (byte_i == 8'd0) begin
              upd.desc_stall = 1'b1;
            end
          end else if (st_q.desc_offset == 8'd1) begin
            upd.desc_kind = byte_i;
          end else if (st_q.desc_kind == udf_pkg::DescKindInterface) begin
            if (upd.in_wanted_cfg && st_q.desc_offset == 8'd2) begin
              upd.cur_interface = byte_i;
            end
            if (upd.in_wanted_cfg && st_q.desc_offset == 8'd3) begin
              upd.cur_alternate = byte_i;
            end
          end else if (st_q.desc_kind == udf_pkg::DescKindEndpoint) begin
            case (st_q.desc_offset)
              8'd2: upd.ep_addr_hold  = byte_i;
              8'd3: upd.ep_attr_hold  = byte_i;
              8'd4: upd.size_low_hold = byte_i;
              8'd5: begin
                ep_match = upd.in_wanted_cfg &&
                           st_q.cur_interface == cfg_i.wanted_interface &&
                           st_q.cur_alternate == cfg_i.wanted_alternate &&
                           st_q.ep_attr_hold[1:0] == cfg_i.wanted_xfer_type &&
                           (st_q.ep_addr_hold & cfg_i.addr_match_mask) ==
                             cfg_i.addr_match_value;
              end
              default: ep_match = 1'b0;
            endcase
          end

          if (ep_match) begin
            upd.match_done     = 1'b1;
            upd.found_endpoint = st_q.ep_addr_hold[3:0];
            upd.found_size     = {byte_i, st_q.size_low_hold};
            upd.walk_over      = 1'b1;
          end

          // A zero length byte leaves the descriptor offset where it is.
          if (!(st_q.desc_offset == 8'd0 && byte_i == 8'd0)) begin
            if ({1'b0, st_q.desc_offset} + 9'd1 >= {1'b0, upd.desc_length}) begin
              upd.desc_offset = 8'd0;
            end else begin
              upd.desc_offset = st_q.desc_offset + 8'd1;
            end
          end
        end

        if (!upd.walk_over) begin
          if (upd.in_wanted_cfg && upd.desc_stall) begin
            upd.walk_over = 1'b1;
          end else begin
            block_end = st_q.cfg_offset >= 16'd3 &&
                        {1'b0, st_q.cfg_offset} + 17'd1 >= {1'b0, upd.cfg_total_len};
            if (block_end) begin
              if (upd.in_wanted_cfg || cnt_inc >= cfg_i.num_configs) begin
                upd.walk_over = 1'b1;
              end
              upd.cfg_count     = cnt_inc;
              upd.cfg_offset    = 16'd0;
              upd.cfg_total_len = 16'd0;
              upd.in_wanted_cfg = 1'b0;
              upd.desc_offset   = 8'd0;
              upd.desc_length   = 8'd0;
              upd.desc_kind     = 8'd0;
              upd.desc_stall    = 1'b0;
            end else begin
              upd.cfg_offset = st_q.cfg_offset + 16'd1;
            end
          end
        end
      end
    end
  end

  // The stream state returns to reset after the byte marked last.
  always_comb begin
    st_d = st_q;
    if (byte_valid_i) begin
      st_d = last_i ? '0 : upd;
    end
  end

  assign res_valid_o           = byte_valid_i && last_i;
  assign res_o.found           = upd.match_done;
  assign res_o.endpoint_number = upd.match_done ? upd.found_endpoint : 4'd0;
  assign res_o.max_packet_size = upd.match_done ? upd.found_size : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  a_found_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.match_done && !(byte_valid_i && last_i)) |=> st_q.match_done)
    else $error("match flag dropped before end of stream");

  a_match_stops_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.match_done |-> st_q.walk_over)
    else $error("walk still running after a match");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_i && last_i) |=> (!st_q.walk_over && !st_q.match_done &&
                                  st_q.cfg_count == 8'd0))
    else $error("stream state not cleared after last byte");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for usb_endpoint_descriptor_finder: streams descriptor
// sets through the byte port and checks each lookup result against a predictor
// or a directed expected value. Depends on udf_pkg and the finder RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam udf_pkg::cfg_t CfgDefault = {8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'h80, 2'd2};
  localparam udf_pkg::cfg_t CfgAllMin  = '0;
  localparam udf_pkg::cfg_t CfgAllMax  = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3};

  typedef struct packed {
    logic [7:0]       b;
    logic             last;
    logic             has_want;
    udf_pkg::result_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [udf_pkg::CfgAddrWidth-1:0] cfg_addr_i;
  logic [udf_pkg::CfgDataWidth-1:0] cfg_wdata_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic m_axis_tuser;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  usb_endpoint_descriptor_finder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit long_hold_go = 1'b0;
  bit long_hold_done = 1'b0;
  int bytes_sent = 0;
  int streams_sent = 0;
  int settings_done = 0;
  int results_seen = 0;
  int err_count = 0;

  udf_pkg::result_t lookup_q[$];
  logic [7:0]       desc_bytes[$];
  dir_row_t         dir_tab[$];

  // Predictor state: register copy plus the walk over the descriptor stream.
  udf_pkg::cfg_t lookup_cfg;
  logic [15:0] blk_pos, blk_len;
  logic [7:0]  blk_done_cnt;
  logic        blk_is_wanted;
  logic [7:0]  dsc_pos, dsc_len, dsc_kind;
  logic [7:0]  cur_intf, cur_alt;
  logic [7:0]  ep_addr_q, ep_attr_q, ep_size_lo;
  logic        hit;
  logic [3:0]  hit_ep;
  logic [15:0] hit_size;
  logic        search_over, dsc_stalled;

  function automatic void lookup_clear_block();
    blk_pos = '0;
    blk_len = '0;
    blk_is_wanted = 1'b0;
    dsc_pos = '0;
    dsc_len = '0;
    dsc_kind = '0;
    dsc_stalled = 1'b0;
  endfunction

  function automatic void lookup_clear_stream();
    lookup_clear_block();
    blk_done_cnt = '0;
    cur_intf = '0;
    cur_alt = '0;
    ep_addr_q = '0;
    ep_attr_q = '0;
    ep_size_lo = '0;
    hit = 1'b0;
    hit_ep = '0;
    hit_size = '0;
    search_over = 1'b0;
  endfunction

  function automatic void lookup_walk(input logic [7:0] b);
    logic [7:0] d;
    d = dsc_pos;
    if (d == 8'd0) begin
      dsc_len = b;
      if (b == 8'd0) begin
        dsc_stalled = 1'b1;
        return;
      end
    end else if (d == 8'd1) begin
      dsc_kind = b;
    end else if (dsc_kind == udf_pkg::DescKindInterface) begin
      if (blk_is_wanted && d == 8'd2) cur_intf = b;
      if (blk_is_wanted && d == 8'd3) cur_alt = b;
    end else if (dsc_kind == udf_pkg::DescKindEndpoint) begin
      if (d == 8'd2) begin
        ep_addr_q = b;
      end else if (d == 8'd3) begin
        ep_attr_q = b;
      end else if (d == 8'd4) begin
        ep_size_lo = b;
      end else if (d == 8'd5 && blk_is_wanted &&
                   cur_intf == lookup_cfg.wanted_interface &&
                   cur_alt == lookup_cfg.wanted_alternate &&
                   ep_attr_q[1:0] == lookup_cfg.wanted_xfer_type &&
                   (ep_addr_q & lookup_cfg.addr_match_mask) ==
                     lookup_cfg.addr_match_value) begin
        hit = 1'b1;
        hit_ep = ep_addr_q[3:0];
        hit_size = {b, ep_size_lo};
        search_over = 1'b1;
      end
    end
    if (int'(d) + 1 >= int'(dsc_len)) dsc_pos = '0;
    else dsc_pos = d + 8'd1;
  endfunction

  function automatic void lookup_take(input logic [7:0] b);
    logic [15:0] o;
    o = blk_pos;
    if (blk_done_cnt >= lookup_cfg.num_configs) begin
      search_over = 1'b1;
      return;
    end
    if (o == 16'd2) blk_len[7:0] = b;
    else if (o == 16'd3) blk_len[15:8] = b;
    else if (o == 16'd5) blk_is_wanted = (b == lookup_cfg.wanted_config_value);
    if (!dsc_stalled) lookup_walk(b);
    if (search_over) return;
    // A zero-length descriptor inside the wanted block ends the search.
    if (blk_is_wanted && dsc_stalled) begin
      search_over = 1'b1;
      return;
    end
    if (o >= 16'd3 && int'(o) + 1 >= int'(blk_len)) begin
      if (blk_is_wanted) search_over = 1'b1;
      blk_done_cnt = blk_done_cnt + 8'd1;
      if (blk_done_cnt >= lookup_cfg.num_configs) search_over = 1'b1;
      lookup_clear_block();
    end else begin
      blk_pos = o + 16'd1;
    end
  endfunction

  function automatic bit lookup_step(input logic [7:0] b, input logic last,
                                     output udf_pkg::result_t r);
    r = '0;
    if (!search_over) lookup_take(b);
    if (!last) return 1'b0;
    r.found = hit;
    r.endpoint_number = hit ? hit_ep : 4'd0;
    r.max_packet_size = hit ? hit_size : 16'd0;
    lookup_clear_stream();
    return 1'b1;
  endfunction

  // Stimulus generation. Field values lean toward the programmed ones so that
  // the walk reaches the endpoint compare often.
  function automatic logic [7:0] near(input logic [7:0] want);
    case ($urandom_range(0, 3))
      0, 1:    return want;
      2:       return want + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_noise(input int n);
    int i;
    for (i = 0; i < n; i++) desc_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_block();
    int start, hdr_len, total, dlen, n, roll, i;
    logic [7:0] kind, f2, f3, f4, f5;
    start = desc_bytes.size();
    hdr_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : 9;
    desc_bytes.push_back(8'(hdr_len));
    desc_bytes.push_back(8'h02);
    desc_bytes.push_back(8'h00);
    desc_bytes.push_back(8'h00);
    desc_bytes.push_back(8'($urandom_range(1, 3)));
    desc_bytes.push_back(near(lookup_cfg.wanted_config_value));
    add_noise(hdr_len - 6);
    for (n = $urandom_range(1, 3); n > 0; n--) begin
      roll = $urandom_range(0, 19);
      f2 = 8'($urandom_range(0, 255));
      f3 = 8'($urandom_range(0, 255));
      f4 = 8'($urandom_range(0, 255));
      f5 = 8'($urandom_range(0, 255));
      if (roll < 8) begin
        dlen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 9;
        kind = udf_pkg::DescKindInterface;
        f2 = near(lookup_cfg.wanted_interface);
        f3 = near(lookup_cfg.wanted_alternate);
      end else if (roll < 16) begin
        dlen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 7;
        kind = udf_pkg::DescKindEndpoint;
        if ($urandom_range(0, 3) != 0)
          f2 = (lookup_cfg.addr_match_value & lookup_cfg.addr_match_mask) |
               (f2 & ~lookup_cfg.addr_match_mask);
        if ($urandom_range(0, 3) != 0) f3[1:0] = lookup_cfg.wanted_xfer_type;
      end else if (roll < 19) begin
        dlen = $urandom_range(2, 12);
        kind = 8'($urandom_range(0, 255));
      end else begin
        dlen = 0;
        kind = '0;
        desc_bytes.push_back(8'h00);
      end
      for (i = 0; i < dlen; i++) begin
        case (i)
          0:       desc_bytes.push_back(8'(dlen));
          1:       desc_bytes.push_back(kind);
          2:       desc_bytes.push_back(f2);
          3:       desc_bytes.push_back(f3);
          4:       desc_bytes.push_back(f4);
          5:       desc_bytes.push_back(f5);
          default: desc_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    total = desc_bytes.size() - start;
    roll = $urandom_range(0, 9);
    if (roll == 0) total = $urandom_range(0, total + 4);
    else if (roll == 1) total = $urandom_range(0, 65535);
    desc_bytes[start + 2] = total[7:0];
    desc_bytes[start + 3] = total[15:8];
  endfunction

  function automatic void build_stream();
    int roll, cut;
    desc_bytes.delete();
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      add_noise($urandom_range(1, 16));
    end else begin
      add_block();
      while ($urandom_range(0, 3) == 0) add_block();
      if (roll == 1) begin
        cut = $urandom_range(1, desc_bytes.size());
        while (desc_bytes.size() > cut) void'(desc_bytes.pop_back());
      end
    end
  endfunction

  function automatic udf_pkg::cfg_t rand_cfg();
    udf_pkg::cfg_t c;
    case ($urandom_range(0, 5))
      0:       c.num_configs = 8'd0;
      1:       c.num_configs = 8'd1;
      2:       c.num_configs = 8'd2;
      3:       c.num_configs = 8'd3;
      4:       c.num_configs = 8'hFF;
      default: c.num_configs = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0:       c.wanted_config_value = 8'd0;
      1:       c.wanted_config_value = 8'd1;
      2:       c.wanted_config_value = 8'd2;
      default: c.wanted_config_value = 8'($urandom_range(0, 255));
    endcase
    c.wanted_interface = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2)) :
                                                       8'($urandom_range(0, 255));
    c.wanted_alternate = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1)) :
                                                       8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0:       c.addr_match_mask = 8'h00;
      1:       c.addr_match_mask = 8'h80;
      2:       c.addr_match_mask = 8'h8F;
      3:       c.addr_match_mask = 8'hFF;
      default: c.addr_match_mask = 8'($urandom_range(0, 255));
    endcase
    c.addr_match_value = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) c.addr_match_value &= c.addr_match_mask;
    c.wanted_xfer_type = 2'($urandom_range(0, 3));
    return c;
  endfunction

  task automatic cfg_write(input udf_pkg::cfg_idx_e idx, input logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
  endtask

  task automatic cfg_load(input udf_pkg::cfg_t c);
    cfg_write(udf_pkg::CfgNumConfigs, c.num_configs);
    cfg_write(udf_pkg::CfgWantedConfig, c.wanted_config_value);
    cfg_write(udf_pkg::CfgWantedIntf, c.wanted_interface);
    cfg_write(udf_pkg::CfgWantedAlt, c.wanted_alternate);
    cfg_write(udf_pkg::CfgAddrMatchValue, c.addr_match_value);
    cfg_write(udf_pkg::CfgAddrMatchMask, c.addr_match_mask);
    cfg_write(udf_pkg::CfgWantedXferType, {6'd0, c.wanted_xfer_type});
    cfg_we_i <= 1'b0;
    lookup_cfg = c;
    settings_done++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic has_want, input udf_pkg::result_t want);
    udf_pkg::result_t got;
    bit has_res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    has_res = lookup_step(b, last, got);
    if (has_res) lookup_q.push_back(has_want ? want : got);
  endtask

  task automatic send_stream();
    foreach (desc_bytes[i])
      send_byte(desc_bytes[i], i == desc_bytes.size() - 1, 1'b0, '0);
    streams_sent++;
  endtask

  // Stop sending and wait for every pending lookup result, then let the
  // block sit idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : result_sink
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_go && !long_hold_done) begin
        // Long hold-off so the output buffer fills and the input backs up.
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    udf_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (lookup_q.size() == 0) begin
        if (err_count < 10)
          $display("tb_top: unexpected result found=%0b ep=%0d size=%04h",
                   m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4]);
        err_count++;
      end else begin
        want = lookup_q.pop_front();
        if (m_axis_tuser !== want.found || m_axis_tdata[3:0] !== want.endpoint_number ||
            m_axis_tdata[19:4] !== want.max_packet_size) begin
          if (err_count < 10)
            $display({"tb_top: mismatch exp found=%0b ep=%0d size=%04h, ",
                      "got found=%0b ep=%0d size=%04h"},
                     want.found, want.endpoint_number, want.max_packet_size,
                     m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4]);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    udf_pkg::cfg_t c;
    int p, phase_start, phase_streams;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = udf_pkg::CfgNumConfigs;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    lookup_cfg = CfgDefault;
    lookup_clear_stream();

    // Directed streams under the reset settings: a lone zero length byte, a
    // full match at the largest endpoint number and packet size, an all-ones
    // fragment, and a zero-length descriptor inside the wanted block.
    dir_tab.push_back({8'h00, 1'b1, 1'b1, 1'b0, 4'h0, 16'h0000});
    dir_tab.push_back({8'h06, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h02, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h0C, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h00, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h01, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h01, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h06, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h05, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h0F, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h02, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'hFF, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'hFF, 1'b1, 1'b1, 1'b1, 4'hF, 16'hFFFF});
    dir_tab.push_back({8'hFF, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'hFF, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'hFF, 1'b1, 1'b1, 1'b0, 4'h0, 16'h0000});
    dir_tab.push_back({8'h06, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h02, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h0C, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h00, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h01, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h01, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h00, 1'b0, 1'b0, 21'h0});
    dir_tab.push_back({8'h05, 1'b1, 1'b1, 1'b0, 4'h0, 16'h0000});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i])
      send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].has_want, dir_tab[i].want);
    settle();

    for (p = 0; p < 8; p++) begin
      if (p == 0) c = CfgAllMin;
      else if (p == 1) c = CfgAllMax;
      else c = rand_cfg();
      cfg_load(c);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 78; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 78; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      phase_start = bytes_sent;
      phase_streams = 0;
      while (bytes_sent - phase_start < 130 || phase_streams < 5) begin
        build_stream();
        send_stream();
        phase_streams++;
      end
      settle();
    end

    // Back-pressure: short streams keep coming while the result side is held.
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    long_hold_go = 1'b1;
    repeat (12) begin
      desc_bytes.delete();
      add_noise(4);
      send_stream();
    end
    settle();

    $display("tb_top: %0d bytes in %0d streams under %0d register settings",
             bytes_sent, streams_sent, settings_done);
    $display("tb_top: %0d lookup results compared, %0d mismatches", results_seen, err_count);
    if (err_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
